// ===== hdl/rc4_pkg.sv =====
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int PERM_SIZE = 256;
  localparam int PW        = 8;

  typedef enum logic {
    OP_KEY,
    OP_DATA
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCH_RD_N,
    ST_SCH_RD_J,
    ST_SCH_WR_N,
    ST_SCH_WR_J,
    ST_DAT_RD_J,
    ST_DAT_WR_I,
    ST_DAT_OUT
  } state_t;

  typedef struct packed {
    logic          cmd;
    logic [PW-1:0] byte_in;
    logic          last;
  } in_item_t;

  typedef struct packed {
    logic [PW-1:0] byte_out;
    logic [PW-1:0] keystream;
    logic          last_out;
  } out_item_t;

  typedef struct packed {
    op_t           op;
    logic [PW-1:0] data;
    logic          last;
  } q_item_t;

endpackage

// ===== hdl/rc4_ram.sv =====
`timescale 1ns / 1ps

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/rc4_front.sv =====
`timescale 1ns / 1ps

module rc4_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rc4_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output rc4_pkg::q_item_t  q_item
);
  import rc4_pkg::*;

  q_item_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  q_item_t    item_in;

  always_comb begin
    item_in.op   = in_data.cmd ? OP_DATA : OP_KEY;
    item_in.data = in_data.byte_in;
    item_in.last = in_data.last;
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/rc4_engine.sv =====
`timescale 1ns / 1ps

module rc4_engine #(
  parameter int KEY_MAX = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  rc4_pkg::q_item_t   q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output rc4_pkg::out_item_t out_data
);
  import rc4_pkg::*;

  localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int CW = $clog2(KEY_MAX + 1);

  state_t state, state_next;

  logic [PW-1:0]        idx_i;
  logic [PW-1:0]        idx_j;
  logic [CW-1:0]        key_count;
  logic [CW-1:0]        key_len;
  logic [KW-1:0]        kidx;
  logic [PW-1:0]        n;
  logic [PW-1:0]        jacc;
  logic [PW-1:0]        si;
  logic [PW-1:0]        sj;
  logic                 hit_i;
  logic                 hit_j;
  logic                 cur_last;
  logic [PW-1:0]        cur_data;
  logic [PERM_SIZE-1:0] vld;
  logic [PW-1:0]        rd_addr_q;
  logic                 rd_vld_q;

  logic                 p_re;
  logic [PW-1:0]        p_raddr;
  logic                 p_we;
  logic [PW-1:0]        p_waddr;
  logic [PW-1:0]        p_wdata;
  logic [PW-1:0]        p_rdata;
  logic [PW-1:0]        p_rd;

  logic                 k_we;
  logic                 k_re;
  logic [PW-1:0]        k_rdata;

  logic                 key_room;
  logic [PW-1:0]        i_next;
  logic [PW-1:0]        j_data;
  logic [PW-1:0]        j_sched;
  logic [PW-1:0]        t_addr;
  logic [PW-1:0]        ks;
  logic [CW-1:0]        kidx_inc;
  logic                 out_load;
  logic                 sched_end;

  rc4_ram #(.WIDTH(PW), .DEPTH(PERM_SIZE)) u_perm (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  rc4_ram #(.WIDTH(PW), .DEPTH(KEY_MAX), .AW(KW)) u_key (
    .clk   (clk),
    .we    (k_we),
    .waddr (key_count[KW-1:0]),
    .wdata (q_item.data),
    .re    (k_re),
    .raddr (kidx),
    .rdata (k_rdata)
  );

  // an entry never written since the last identity reset reads as its own index
  assign p_rd     = rd_vld_q ? p_rdata : rd_addr_q;
  assign key_room = (key_count < CW'(KEY_MAX));
  assign i_next   = idx_i + 8'd1;
  assign j_data   = idx_j + p_rd;
  assign j_sched  = jacc + p_rd + k_rdata;
  assign t_addr   = si + p_rd;
  assign ks       = hit_j ? si : (hit_i ? sj : p_rd);
  assign kidx_inc = CW'(kidx) + CW'(1);
  assign out_load = (state == ST_DAT_OUT) && (!out_valid || out_ready);
  assign sched_end = (state == ST_SCH_WR_J) && (n == PW'(PERM_SIZE - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.op == OP_DATA) begin
            state_next = ST_DAT_RD_J;
          end else if (q_item.last) begin
            state_next = ST_SCH_RD_N;
          end
        end
      end
      ST_SCH_RD_N: state_next = ST_SCH_RD_J;
      ST_SCH_RD_J: state_next = ST_SCH_WR_N;
      ST_SCH_WR_N: state_next = ST_SCH_WR_J;
      ST_SCH_WR_J: state_next = sched_end ? ST_IDLE : ST_SCH_RD_N;
      ST_DAT_RD_J: state_next = ST_DAT_WR_I;
      ST_DAT_WR_I: state_next = ST_DAT_OUT;
      ST_DAT_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = 1'b0;
    p_re    = 1'b0;
    p_raddr = i_next;
    p_we    = 1'b0;
    p_waddr = n;
    p_wdata = si;
    k_we    = 1'b0;
    k_re    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_item.op == OP_DATA) begin
            p_re = 1'b1;
          end else begin
            k_we = key_room;
          end
        end
      end
      ST_SCH_RD_N: begin
        p_re    = 1'b1;
        p_raddr = n;
        k_re    = 1'b1;
      end
      ST_SCH_RD_J: begin
        p_re    = 1'b1;
        p_raddr = j_sched;
      end
      ST_SCH_WR_N: begin
        p_we    = 1'b1;
        p_waddr = n;
        p_wdata = p_rd;
      end
      ST_SCH_WR_J: begin
        p_we    = 1'b1;
        p_waddr = jacc;
        p_wdata = si;
      end
      ST_DAT_RD_J: begin
        p_re    = 1'b1;
        p_raddr = j_data;
      end
      ST_DAT_WR_I: begin
        p_we    = 1'b1;
        p_waddr = idx_i;
        p_wdata = p_rd;
        p_re    = 1'b1;
        p_raddr = t_addr;
      end
      ST_DAT_OUT: begin
        p_we    = 1'b1;
        p_waddr = idx_j;
        p_wdata = si;
      end
      default: begin
        q_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_re) begin
      rd_addr_q <= p_raddr;
      rd_vld_q  <= vld[p_raddr];
    end
    unique case (state)
      ST_IDLE: begin
        cur_data <= q_item.data;
        cur_last <= q_item.last;
        n        <= '0;
        jacc     <= '0;
        kidx     <= '0;
        key_len  <= key_room ? key_count + CW'(1) : key_count;
      end
      ST_SCH_RD_J: begin
        si   <= p_rd;
        jacc <= j_sched;
      end
      ST_SCH_WR_J: begin
        n    <= n + 8'd1;
        kidx <= (kidx_inc == key_len) ? '0 : kidx_inc[KW-1:0];
      end
      ST_DAT_RD_J: begin
        si <= p_rd;
      end
      ST_DAT_WR_I: begin
        sj    <= p_rd;
        hit_i <= (t_addr == idx_i);
        hit_j <= (t_addr == idx_j);
      end
      default: begin
        si <= si;
      end
    endcase
    if (out_load) begin
      out_data.byte_out  <= cur_data ^ ks;
      out_data.keystream <= ks;
      out_data.last_out  <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx_i     <= '0;
      idx_j     <= '0;
      key_count <= '0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (p_we) begin
        vld[p_waddr] <= 1'b1;
      end
      if (state == ST_IDLE && q_valid) begin
        if (q_item.op == OP_DATA) begin
          idx_i <= i_next;
        end else begin
          if (key_room) begin
            key_count <= key_count + CW'(1);
          end
          // schedule starts from identity
          if (q_item.last) begin
            vld <= '0;
          end
        end
      end
      if (state == ST_DAT_RD_J) begin
        idx_j <= j_data;
      end
      if (sched_end) begin
        idx_i     <= '0;
        idx_j     <= '0;
        key_count <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_key_count_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= CW'(KEY_MAX))
    else $error("key_count beyond key store depth");

  a_kidx_in_key: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCH_RD_N) |-> (key_len != '0) && (CW'(kidx) < key_len))
    else $error("key index outside loaded key");

  a_sched_clears: assert property (@(posedge clk) disable iff (rst)
    sched_end |=> (idx_i == '0) && (idx_j == '0) && (key_count == '0))
    else $error("indices not cleared after schedule");

  a_out_from_data: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DAT_OUT)
    else $error("result raised outside data completion");

endmodule

// ===== hdl/rc4_stream_cipher.sv =====
`timescale 1ns / 1ps
// Data beat: reads S[i] and S[j], writes S[i] and reads S[t], writes S[j], then
// registers the result before it takes the next beat, as the permutation memory has a
// single read and single write port. The last key beat adds a 256-entry schedule.
// Two-beat input queue accepts until full while the engine works or a result waits.
// Reset (rst, synchronous): permutation reads as identity via per-entry valid bits,
// indices and key count cleared; no clearing pass. Key storage is not cleared.
module rc4_stream_cipher #(
  parameter int KEY_MAX = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rc4_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rc4_pkg::out_item_t out_data
);
  import rc4_pkg::*;

  logic    q_valid;
  logic    q_ready;
  q_item_t q_item;

  rc4_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  rc4_engine #(.KEY_MAX(KEY_MAX)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
